// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// No dependencies; used by the front, back and top level.
`default_nettype none
package i2cm_pkg;

  localparam int unsigned TICKS_W         = 16;
  localparam int unsigned PHASE_TICKS_RST = 1000;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned IN_TDATA_W      = 16;
  localparam int unsigned OUT_TDATA_W     = 16;

  // one classified item, as it travels from the front to the back
  typedef struct packed {
    logic       is_tick;
    logic       is_read;
    logic [7:0] tx_byte;
    logic       send_start;
    logic       send_stop;
    logic       sda_in;
  } item_t;

  // queue head as the back sees it
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage
`default_nettype wire

// ===== rtl/i2cm_front.sv =====
// Input side: accepts stream beats, classifies them as command or tick and
// holds them in a short queue. Depends on i2cm_pkg.
`default_nettype none
module i2cm_front #(
  parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  wire                                logic clk,
  input  wire                                logic rst_n,
  input  wire                                logic in_tvalid,
  output logic                               in_tready,
  input  wire logic [i2cm_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire                                logic in_tuser,
  output i2cm_pkg::head_t                    head,
  input  wire                                logic pop
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  i2cm_pkg::item_t             mem_r [DEPTH];
  i2cm_pkg::item_t             item_c;
  logic [PTR_W-1:0]            wr_ptr_r;
  logic [PTR_W-1:0]            rd_ptr_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic                        push;
  logic                        do_pop;

  // classify: a tick carries only the SDA sample, a command only its fields
  always_comb begin
    item_c            = '0;
    item_c.is_tick    = in_tuser;
    if (in_tuser) begin
      item_c.sda_in     = in_tdata[11];
    end else begin
      item_c.is_read    = in_tdata[0];
      item_c.tx_byte    = in_tdata[8:1];
      item_c.send_start = in_tdata[9];
      item_c.send_stop  = in_tdata[10];
    end
  end

  assign in_tready  = (count_r != FULL_CNT);
  assign push       = in_tvalid && in_tready;
  assign do_pop     = pop && (count_r != '0);
  assign head       = '{valid: (count_r != '0), item: mem_r[rd_ptr_r]};

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ===== rtl/i2cm_back.sv =====
// Execution side: runs the I2C pin sequencer one queued beat at a time and
// holds the result beat in an output register. Depends on i2cm_pkg.
`default_nettype none
module i2cm_back (
  input  wire                                  logic clk,
  input  wire                                  logic rst_n,
  input  wire i2cm_pkg::head_t                 head,
  output logic                                 pop,
  input  wire                                  logic cfg_wr_en,
  input  wire logic [i2cm_pkg::TICKS_W-1:0]    cfg_wr_data,
  output logic                                 out_tvalid,
  input  wire                                  logic out_tready,
  output logic [i2cm_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_ST_A    = 5'd1;
  localparam logic [4:0] PH_ST_B    = 5'd2;
  localparam logic [4:0] PH_ST_C    = 5'd3;
  localparam logic [4:0] PH_ST_D    = 5'd4;
  localparam logic [4:0] PH_WR_DATA = 5'd5;
  localparam logic [4:0] PH_WR_HIGH = 5'd6;
  localparam logic [4:0] PH_WR_LOW  = 5'd7;
  localparam logic [4:0] PH_AK_REL  = 5'd8;
  localparam logic [4:0] PH_AK_HIGH = 5'd9;
  localparam logic [4:0] PH_AK_LOW  = 5'd10;
  localparam logic [4:0] PH_RD_REL  = 5'd11;
  localparam logic [4:0] PH_RD_HIGH = 5'd12;
  localparam logic [4:0] PH_RD_LOW  = 5'd13;
  localparam logic [4:0] PH_RA_DATA = 5'd14;
  localparam logic [4:0] PH_RA_HIGH = 5'd15;
  localparam logic [4:0] PH_RA_LOW  = 5'd16;
  localparam logic [4:0] PH_SP_A    = 5'd17;
  localparam logic [4:0] PH_SP_B    = 5'd18;
  localparam logic [4:0] PH_SP_C    = 5'd19;

  localparam int unsigned FLAG_READ  = 0;
  localparam int unsigned FLAG_START = 1;
  localparam int unsigned FLAG_STOP  = 2;
  localparam logic [3:0]  BYTE_BITS  = 4'd8;

  logic [i2cm_pkg::TICKS_W-1:0]     ticks_r;
  logic [4:0]                       phase_r, phase_nxt;
  logic [3:0]                       bit_cnt_r, bit_cnt_nxt;
  logic [7:0]                       shift_r, shift_nxt;
  logic [i2cm_pkg::TICKS_W-1:0]     hold_r, hold_nxt;
  logic                             scl_r, scl_nxt;
  logic                             sda_r, sda_nxt;
  logic                             sda_en_r, sda_en_nxt;
  logic [2:0]                       flags_r, flags_nxt;
  logic                             ack_r, ack_nxt;
  logic [7:0]                       rx_r, rx_nxt;
  logic                             done_c, rej_c;
  logic                             enter_c;
  logic [4:0]                       target_c;
  logic                             out_valid_r;
  logic [i2cm_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [i2cm_pkg::OUT_TDATA_W-1:0] pack_c;
  i2cm_pkg::item_t                  it;

  assign it  = head.item;
  assign pop = head.valid && (!out_valid_r || out_tready);

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    hold_nxt    = hold_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    sda_en_nxt  = sda_en_r;
    flags_nxt   = flags_r;
    ack_nxt     = ack_r;
    rx_nxt      = rx_r;
    done_c      = 1'b0;
    rej_c       = 1'b0;
    enter_c     = 1'b0;
    target_c    = PH_IDLE;

    if (!it.is_tick) begin
      if (phase_r != PH_IDLE) begin
        rej_c = 1'b1;
      end else begin
        flags_nxt   = {it.send_stop, it.send_start, it.is_read};
        shift_nxt   = it.is_read ? 8'h00 : it.tx_byte;
        bit_cnt_nxt = '0;
        enter_c     = 1'b1;
        if (it.send_start) begin
          target_c = PH_ST_A;
        end else begin
          target_c = it.is_read ? PH_RD_REL : PH_WR_DATA;
        end
      end
    end else if (phase_r != PH_IDLE) begin
      hold_nxt = hold_r - 1'b1;
      if (hold_nxt == '0) begin
        unique case (phase_r) inside
          PH_ST_D: begin
            enter_c  = 1'b1;
            target_c = flags_r[FLAG_READ] ? PH_RD_REL : PH_WR_DATA;
          end
          PH_WR_LOW: begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_cnt_nxt = bit_cnt_r + 1'b1;
            enter_c     = 1'b1;
            target_c    = (bit_cnt_nxt < BYTE_BITS) ? PH_WR_DATA : PH_AK_REL;
          end
          PH_AK_HIGH: begin
            ack_nxt  = it.sda_in;
            enter_c  = 1'b1;
            target_c = PH_AK_LOW;
          end
          PH_AK_LOW, PH_RA_LOW: begin
            if (flags_r[FLAG_STOP]) begin
              enter_c  = 1'b1;
              target_c = PH_SP_A;
            end else begin
              phase_nxt = PH_IDLE;
              done_c    = 1'b1;
            end
          end
          PH_RD_HIGH: begin
            shift_nxt   = {shift_r[6:0], it.sda_in};
            bit_cnt_nxt = bit_cnt_r + 1'b1;
            enter_c     = 1'b1;
            target_c    = PH_RD_LOW;
          end
          PH_RD_LOW: begin
            enter_c = 1'b1;
            if (bit_cnt_r < BYTE_BITS) begin
              target_c = PH_RD_HIGH;
            end else begin
              rx_nxt   = shift_r;
              target_c = PH_RA_DATA;
            end
          end
          PH_SP_C: begin
            phase_nxt = PH_IDLE;
            done_c    = 1'b1;
          end
          default: begin
            enter_c  = 1'b1;
            target_c = phase_r + 1'b1;
          end
        endcase
      end
    end

    // phase entry: reload the hold counter and set the pins for the new phase
    if (enter_c) begin
      phase_nxt = target_c;
      hold_nxt  = (ticks_r == '0) ? {{(i2cm_pkg::TICKS_W-1){1'b0}}, 1'b1} : ticks_r;
      unique case (target_c) inside
        PH_ST_A:    begin sda_nxt = 1'b1; sda_en_nxt = 1'b1; end
        PH_ST_C:    sda_nxt = 1'b0;
        PH_ST_D, PH_WR_LOW, PH_RD_LOW, PH_RA_LOW: scl_nxt = 1'b0;
        PH_ST_B, PH_WR_HIGH, PH_AK_HIGH, PH_RD_HIGH, PH_RA_HIGH, PH_SP_B:
          scl_nxt = 1'b1;
        PH_WR_DATA: begin sda_nxt = shift_nxt[7]; sda_en_nxt = 1'b1; end
        PH_AK_REL, PH_RD_REL: sda_en_nxt = 1'b0;
        PH_AK_LOW:  begin scl_nxt = 1'b0; sda_en_nxt = 1'b1; end
        PH_RA_DATA: begin sda_nxt = flags_nxt[FLAG_STOP]; sda_en_nxt = 1'b1; end
        PH_SP_A:    begin sda_nxt = 1'b0; sda_en_nxt = 1'b1; end
        PH_SP_C:    sda_nxt = 1'b1;
        default: begin
          phase_nxt = PH_IDLE;
          hold_nxt  = '0;
        end
      endcase
    end
  end

  // result beat: scl, sda_out, sda_drive, busy, done, rx_byte, ack_level, rejected
  assign pack_c = {1'b0, rej_c, ack_nxt, rx_nxt, done_c, (phase_nxt != PH_IDLE),
                   sda_en_nxt, sda_nxt, scl_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= i2cm_pkg::TICKS_W'(i2cm_pkg::PHASE_TICKS_RST);
    end else if (cfg_wr_en) begin
      ticks_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      hold_r    <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      sda_en_r  <= 1'b1;
      flags_r   <= '0;
      ack_r     <= 1'b0;
      rx_r      <= '0;
    end else if (pop) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      hold_r    <= hold_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      sda_en_r  <= sda_en_nxt;
      flags_r   <= flags_nxt;
      ack_r     <= ack_nxt;
      rx_r      <= rx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= pack_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) == (hold_r == '0))
    else $error("hold counter out of step with phase");

  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= BYTE_BITS)
    else $error("bit counter past one byte");

  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    pop && rej_c |=> phase_r == $past(phase_r) && hold_r == $past(hold_r))
    else $error("rejected command changed the sequencer");

endmodule
`default_nettype wire

// ===== rtl/i2c_master_byte_engine.sv =====
// I2C master byte engine: one beat in, one result beat out, one beat per cycle
// sustained while out_tready keeps the output register free. An accepted beat is
// queued, then goes from the queue head through the sequencer into the output
// register. The 2-entry queue decouples input stalls from output stalls; the
// sequencer step is combinational. Synchronous active-low reset empties the queue,
// sets the bus idle with SCL and SDA driven high, loads phase_ticks = 1000.
`default_nettype none
module i2c_master_byte_engine #(
  parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  wire                                  logic clk,
  input  wire                                  logic rst_n,
  input  wire                                  logic in_tvalid,
  output logic                                 in_tready,
  // is_read, tx_byte[7:0], send_start, send_stop, sda_in, zero pad
  input  wire logic [i2cm_pkg::IN_TDATA_W-1:0] in_tdata,
  // kind
  input  wire                                  logic in_tuser,
  output logic                                 out_tvalid,
  input  wire                                  logic out_tready,
  // scl, sda_out, sda_drive, busy_res, done_res, rx_byte[7:0], ack_level,
  // rejected, zero pad
  output logic [i2cm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  wire                                  logic cfg_wr_en,
  input  wire logic [i2cm_pkg::TICKS_W-1:0]    cfg_wr_data
);

  i2cm_pkg::head_t head;
  logic            pop;

  i2cm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .pop       (pop)
  );

  i2cm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

// ===== bench/i2c_master_byte_engine_test.sv =====
// Self-checking bench for i2c_master_byte_engine: drives command and tick beats,
// predicts every status beat with its own bus sequencer, and scores the output.
// Depends on rtl/i2cm_pkg.sv and rtl/i2c_master_byte_engine.sv.
`timescale 1ns / 1ps
module i2c_master_byte_engine_test;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [2:0] FLG_READ  = 3'b001;
  localparam logic [2:0] FLG_START = 3'b010;
  localparam logic [2:0] FLG_STOP  = 3'b100;

  localparam int SDA_LOW    = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_RANDOM = 2;

  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int BEATS_PER_MODE = 320;

  typedef enum logic [4:0] {
    BUS_IDLE, STA_SDA_HI, STA_SCL_HI, STA_SDA_LO, STA_SCL_LO,
    WR_BIT_SET, WR_SCL_HI, WR_SCL_LO, ACK_RELEASE, ACK_SCL_HI, ACK_SCL_LO,
    RD_RELEASE, RD_SCL_HI, RD_SCL_LO, MACK_SET, MACK_SCL_HI, MACK_SCL_LO,
    STP_SDA_LO, STP_SCL_HI, STP_SDA_HI
  } phase_e;

  // in_tdata layout, lowest bit last
  typedef struct packed {
    logic [3:0] pad;
    logic       sda_in;
    logic       send_stop;
    logic       send_start;
    logic [7:0] tx_byte;
    logic       is_read;
  } cmd_word_t;

  // out_tdata layout, lowest bit last
  typedef struct packed {
    logic       pad;
    logic       rejected;
    logic       ack_level;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       sda_drive;
    logic       sda_out;
    logic       scl;
  } bus_status_t;

  class i2c_byte_scoreboard;
    phase_e      phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [15:0] hold_count;
    logic [15:0] phase_ticks;
    logic        scl_level, sda_level, sda_enable, ack_seen;
    logic [2:0]  pending;
    logic [7:0]  rx_latch;
    bus_status_t expected_q[$];
    int          errors, checked, rejects, dones;

    function new();
      phase_ticks = 16'(i2cm_pkg::PHASE_TICKS_RST);
      phase       = BUS_IDLE;
      bit_count   = '0;
      shift_reg   = '0;
      hold_count  = '0;
      scl_level   = 1'b1;
      sda_level   = 1'b1;
      sda_enable  = 1'b1;
      pending     = '0;
      ack_seen    = 1'b0;
      rx_latch    = '0;
      errors      = 0;
      checked     = 0;
      rejects     = 0;
      dones       = 0;
    endfunction

    function bit busy();
      return phase != BUS_IDLE;
    endfunction

    function void load_phase(phase_e p);
      phase      = p;
      hold_count = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
      case (p)
        STA_SDA_HI: begin
          sda_level  = 1'b1;
          sda_enable = 1'b1;
        end
        STA_SCL_HI, WR_SCL_HI, ACK_SCL_HI, RD_SCL_HI, MACK_SCL_HI, STP_SCL_HI:
          scl_level = 1'b1;
        STA_SDA_LO: sda_level = 1'b0;
        STA_SCL_LO, WR_SCL_LO, RD_SCL_LO, MACK_SCL_LO: scl_level = 1'b0;
        WR_BIT_SET: begin
          sda_level  = shift_reg[7];
          sda_enable = 1'b1;
        end
        ACK_RELEASE, RD_RELEASE: sda_enable = 1'b0;
        ACK_SCL_LO: begin
          scl_level  = 1'b0;
          sda_enable = 1'b1;
        end
        // NACK when a stop follows the read
        MACK_SET: begin
          sda_level  = (pending & FLG_STOP) != 0;
          sda_enable = 1'b1;
        end
        STP_SDA_LO: begin
          sda_level  = 1'b0;
          sda_enable = 1'b1;
        end
        STP_SDA_HI: sda_level = 1'b1;
        default: begin
          phase      = BUS_IDLE;
          hold_count = '0;
        end
      endcase
    endfunction

    // close the current phase; returns 1 when the transfer is over
    function bit end_phase(logic sda);
      case (phase)
        STA_SCL_LO: load_phase((pending & FLG_READ) != 0 ? RD_RELEASE : WR_BIT_SET);
        WR_SCL_LO: begin
          shift_reg = shift_reg << 1;
          bit_count = bit_count + 4'd1;
          load_phase(bit_count < 4'd8 ? WR_BIT_SET : ACK_RELEASE);
        end
        ACK_SCL_HI: begin
          ack_seen = sda;
          load_phase(ACK_SCL_LO);
        end
        ACK_SCL_LO, MACK_SCL_LO: begin
          if ((pending & FLG_STOP) != 0) begin
            load_phase(STP_SDA_LO);
          end else begin
            phase      = BUS_IDLE;
            hold_count = '0;
            return 1'b1;
          end
        end
        RD_SCL_HI: begin
          shift_reg = {shift_reg[6:0], sda};
          bit_count = bit_count + 4'd1;
          load_phase(RD_SCL_LO);
        end
        RD_SCL_LO: begin
          if (bit_count < 4'd8) begin
            load_phase(RD_SCL_HI);
          end else begin
            rx_latch = shift_reg;
            load_phase(MACK_SET);
          end
        end
        STP_SDA_HI: begin
          phase      = BUS_IDLE;
          hold_count = '0;
          return 1'b1;
        end
        BUS_IDLE: ;
        default: load_phase(phase_e'(phase + 5'd1));
      endcase
      return 1'b0;
    endfunction

    function void note_input(logic kind, cmd_word_t w);
      bus_status_t r;
      r = '0;
      if (kind == KIND_CMD) begin
        if (phase != BUS_IDLE) begin
          r.rejected = 1'b1;
          rejects++;
        end else begin
          pending   = {w.send_stop, w.send_start, w.is_read};
          shift_reg = w.is_read ? 8'h00 : w.tx_byte;
          bit_count = '0;
          if ((pending & FLG_START) != 0) load_phase(STA_SDA_HI);
          else load_phase(w.is_read ? RD_RELEASE : WR_BIT_SET);
        end
      end else if (phase != BUS_IDLE) begin
        hold_count = hold_count - 16'd1;
        if (hold_count == 16'd0) r.done = end_phase(w.sda_in);
      end
      if (r.done) dones++;
      r.scl       = scl_level;
      r.sda_out   = sda_level;
      r.sda_drive = sda_enable;
      r.busy      = phase != BUS_IDLE;
      r.rx_byte   = rx_latch;
      r.ack_level = ack_seen;
      expected_q.push_back(r);
    endfunction

    function string describe(bus_status_t s);
      return $sformatf("scl=%b sda=%b drv=%b busy=%b done=%b rx=%h ack=%b rej=%b",
                       s.scl, s.sda_out, s.sda_drive, s.busy, s.done, s.rx_byte,
                       s.ack_level, s.rejected);
    endfunction

    function void check_result(bus_status_t got);
      bus_status_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: status beat with none expected: %s", $time, describe(got));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.scl !== want.scl || got.sda_out !== want.sda_out ||
          got.sda_drive !== want.sda_drive || got.busy !== want.busy ||
          got.done !== want.done || got.rx_byte !== want.rx_byte ||
          got.ack_level !== want.ack_level || got.rejected !== want.rejected) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: status beat %0d mismatch", $time, checked);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  i2c_byte_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_asks = 0;
  int stall_served = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int counted = 0;
  int transfers = 0;

  i2c_master_byte_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_asks) begin
      out_tready   <= 1'b0;
      stall_left   <= STALL_CYCLES;
      stall_served <= stall_asks;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(bus_status_t'(out_tdata));
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic cmd_word_t random_word();
    cmd_word_t w;
    w     = cmd_word_t'(16'($urandom));
    w.pad = '0;
    return w;
  endfunction

  // valid stays high between back-to-back beats; lowered only for a gap
  task automatic send_beat(input logic kind, input cmd_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_CMD || sb.busy()) counted++;
    sb.note_input(kind, w);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_phase_ticks(input logic [15:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    sb.phase_ticks  = value;
  endtask

  // one command, then ticks until the bus is idle; noise_pct of the
  // beats in between are commands that must be dropped
  task automatic do_transfer(input logic rd, input logic [7:0] data, input logic st,
                             input logic sp, input int sda_mode, input int noise_pct);
    cmd_word_t w;
    w            = random_word();
    w.is_read    = rd;
    w.tx_byte    = data;
    w.send_start = st;
    w.send_stop  = sp;
    send_beat(KIND_CMD, w);
    while (sb.busy()) begin
      w = random_word();
      if ($urandom_range(99) < noise_pct) begin
        send_beat(KIND_CMD, w);
      end else begin
        if (sda_mode == SDA_LOW) w.sda_in = 1'b0;
        else if (sda_mode == SDA_HIGH) w.sda_in = 1'b1;
        send_beat(KIND_TICK, w);
      end
    end
    transfers++;
  endtask

  task automatic random_transfer();
    int pick;
    int sda_mode;
    pick     = $urandom_range(9);
    sda_mode = (pick == 0) ? SDA_LOW : (pick == 1) ? SDA_HIGH : SDA_RANDOM;
    do_transfer(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1)), sda_mode, 4);
  endtask

  initial begin
    int pick;
    logic [15:0] ticks_val;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero length behaves as one tick
    set_phase_ticks(16'd0);
    send_beat(KIND_TICK, random_word());
    do_transfer(1'b0, 8'h00, 1'b0, 1'b0, SDA_LOW, 0);
    do_transfer(1'b0, 8'hFF, 1'b1, 1'b1, SDA_HIGH, 0);
    do_transfer(1'b1, 8'h5A, 1'b1, 1'b0, SDA_HIGH, 0);
    do_transfer(1'b1, 8'hA5, 1'b0, 1'b1, SDA_LOW, 0);
    do_transfer(1'b0, 8'h80, 1'b1, 1'b0, SDA_RANDOM, 10);
    do_transfer(1'b0, 8'h01, 1'b0, 1'b1, SDA_RANDOM, 10);
    do_transfer(1'b1, 8'h00, 1'b0, 1'b0, SDA_RANDOM, 0);
    do_transfer(1'b0, 8'h7E, 1'b0, 1'b0, SDA_RANDOM, 0);
    send_beat(KIND_TICK, random_word());
    set_phase_ticks(16'd2);
    do_transfer(1'b1, 8'h3C, 1'b1, 1'b1, SDA_RANDOM, 10);

    counted = 0;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 86 : 0;
      recv_idle_pct = (mode == 0) ? 86 : (mode == 1) ? 11 : 0;
      if (mode == 2) stall_asks++;
      while (counted < (mode + 1) * BEATS_PER_MODE) begin
        if ($urandom_range(9) == 0) begin
          pick      = $urandom_range(19);
          ticks_val = (pick < 12) ? 16'd1 : (pick < 15) ? 16'd0 : (pick < 18) ? 16'd2 : 16'd3;
          set_phase_ticks(ticks_val);
        end
        if ($urandom_range(9) == 0) send_beat(KIND_TICK, random_word());
        random_transfer();
      end
      // hold the sender until every status beat is back
      drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      sb.errors++;
      $display("%0d status beats never arrived", sb.expected_q.size());
    end
    $display("Covered %0d transfers and %0d dropped commands at phase lengths 0-3.",
             transfers, sb.rejects);
    $display("Checked %0d status beats, %0d of them ending a transfer; %0d errors.",
             sb.checked, sb.dones, sb.errors);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
